### design/device_dispatch_selector_defines.svh
// assertion macros for the device dispatch selector
`ifndef DEVICE_DISPATCH_SELECTOR_DEFINES_SVH
`define DEVICE_DISPATCH_SELECTOR_DEFINES_SVH
// concurrent check, disabled during reset
`define DDS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// check that also holds while reset is asserted
`define DDS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

### design/dds_pkg.sv
// types, constants and helpers for the device dispatch selector
package dds_pkg;

    localparam int DEVICE_SLOTS_DEF    = 16;
    localparam int CAPS_PER_DEVICE_DEF = 8;
    localparam int FALLBACK_SLOTS_DEF  = 4;

    localparam logic [2:0] KIND_ADD_DEV  = 3'd0;
    localparam logic [2:0] KIND_ADD_CAP  = 3'd1;
    localparam logic [2:0] KIND_LOOKUP   = 3'd2;
    localparam logic [2:0] KIND_ACQ_HINT = 3'd3;
    localparam logic [2:0] KIND_ACQ_PREF = 3'd4;
    localparam logic [2:0] KIND_RELEASE  = 3'd5;
    localparam logic [2:0] KIND_RSVD_6   = 3'd6;
    localparam logic [2:0] KIND_RSVD_7   = 3'd7;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;

    localparam logic [1:0] PREF_SEC  = 2'd1;
    localparam logic [1:0] PREF_EFF  = 2'd2;
    localparam logic [1:0] PREF_RSVD = 2'd3;

    localparam logic [2:0] TYPE_ANY = 3'd0;
    localparam logic [2:0] TYPE_END = 3'd7;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  dev_num;
        logic [2:0]  device_type;
        logic        enabled;
        logic [7:0]  credit_max;
        logic [7:0]  priority_req;
        logic [15:0] scores;
        logic [3:0]  domain;
        logic [3:0]  action;
        logic [7:0]  algorithm;
        logic [1:0]  preference;
        logic [11:0] fallback_types;
    } dds_in_t;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] slot;
        logic [7:0] granted_id;
        logic [7:0] inflight_now;
    } dds_out_t;

    // per-device record as held in the device table
    typedef struct packed {
        logic [7:0]  id;
        logic [2:0]  dtype;
        logic        enabled;
        logic [7:0]  limit;
        logic [7:0]  prio;
        logic [15:0] scores;
    } dds_dev_t;

    // capability match: domain, action equal and algorithm equal or auto
    function automatic logic cap_match(input logic [15:0] cap, input logic [3:0] dom,
                                       input logic [3:0] act, input logic [7:0] alg);
        cap_match = (cap[15:12] == dom) && (cap[11:8] == act) &&
                    ((cap[7:0] == alg) || (cap[7:0] == 8'd0));
    endfunction

endpackage

### design/device_dispatch_selector.sv
// device dispatch selector top level: device table, sequencer and capability ram
//
// one command channel, one result channel. a command beat is taken when start
// is high and busy is low; busy then stays high until the cycle in which its single
// result beat is shown on res with done high. the receiver cannot stall.
// a command walks the device slots one at a time under a small sequencer; for
// each qualifying slot the stored capabilities are read from the capability ram,
// one entry a cycle until one matches. the shared rank unit compares each
// qualifying slot with the running best.
// add device writes the table directly; lookup, release and add capability
// match slots by device number; acquire by hint stops at the first enabled slot
// with that number, free credit and a matching capability; acquire by preference
// rescans the slots per fallback type until one is chosen, up to FALLBACK_SLOTS passes.
// reset clears the device count and the sequencer; table contents stay
// undefined until written. a new command is taken as early as the done cycle.
module device_dispatch_selector
    import dds_pkg::*;
#(
    parameter int DEVICE_SLOTS    = DEVICE_SLOTS_DEF,
    parameter int CAPS_PER_DEVICE = CAPS_PER_DEVICE_DEF,
    parameter int FALLBACK_SLOTS  = FALLBACK_SLOTS_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  dds_in_t  cmd,
    output logic     busy,
    output logic     done,
    output dds_out_t res
);
    `include "device_dispatch_selector_defines.svh"

    localparam int SW = (DEVICE_SLOTS > 1) ? $clog2(DEVICE_SLOTS) : 1;
    localparam int CW = (CAPS_PER_DEVICE > 1) ? $clog2(CAPS_PER_DEVICE) : 1;
    localparam int AW = $clog2(DEVICE_SLOTS * CAPS_PER_DEVICE) > 0 ?
                        $clog2(DEVICE_SLOTS * CAPS_PER_DEVICE) : 1;
    localparam int NW = $clog2(DEVICE_SLOTS + 1);
    localparam int KW = $clog2(CAPS_PER_DEVICE + 1);
    localparam int OW = (FALLBACK_SLOTS > 1) ? $clog2(FALLBACK_SLOTS) : 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SLOT = 3'd1;
    localparam logic [2:0] S_CAP  = 3'd2;
    localparam logic [2:0] S_NEXT = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]   state_reg, state_next;
    logic [NW-1:0] count_reg, count_next;
    dds_in_t      cmd_reg, cmd_next;
    logic [SW-1:0] idx_reg, idx_next;
    logic [KW-1:0] cap_reg, cap_next;
    logic         rd_pend_reg, rd_pend_next;
    logic         sup_reg, sup_next;
    logic [OW-1:0] ord_reg, ord_next;
    logic         have_reg, have_next;
    logic [SW-1:0] best_reg, best_next;
    dds_out_t     res_reg, res_next;
    logic         done_reg, done_next;

    dds_dev_t     dev_reg [DEVICE_SLOTS];
    logic [7:0]   infl_reg [DEVICE_SLOTS];
    logic [KW-1:0] ccnt_reg [DEVICE_SLOTS];

    logic         dev_we, infl_we, ccnt_we;
    logic [SW-1:0] w_idx, infl_idx;
    logic [7:0]   infl_val;
    logic [KW-1:0] ccnt_val;

    logic         ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [15:0]  ram_wdata, ram_rdata;

    logic         beats;
    logic [2:0]   cur_type;
    logic         last_slot;
    logic [31:0]  fb_wide;

    dds_ram #(.WIDTH(16), .DEPTH(DEVICE_SLOTS * CAPS_PER_DEVICE)) u_cap_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    dds_rank u_rank (
        .preference(cmd_reg.preference),
        .cand      (dev_reg[idx_reg]),
        .cand_infl (infl_reg[idx_reg]),
        .best      (dev_reg[best_reg]),
        .best_infl (infl_reg[best_reg]),
        .beats     (beats)
    );

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign res  = res_reg;

    always_comb
    begin
        fb_wide   = {20'd0, cmd_reg.fallback_types} >> (3 * 32'(ord_reg));
        cur_type  = (3 * 32'(ord_reg) < 12) ? fb_wide[2:0] : TYPE_ANY;
        last_slot = (NW'(idx_reg) + NW'(1) >= count_reg);
        ram_raddr = AW'(32'(idx_reg) * CAPS_PER_DEVICE + 32'(cap_reg[CW-1:0]));
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        cmd_next     = cmd_reg;
        idx_next     = idx_reg;
        cap_next     = cap_reg;
        rd_pend_next = 1'b0;
        sup_next     = sup_reg;
        ord_next     = ord_reg;
        have_next    = have_reg;
        best_next    = best_reg;
        res_next     = res_reg;
        done_next    = 1'b0;
        dev_we       = 1'b0;
        w_idx        = count_reg[SW-1:0];
        infl_we      = 1'b0;
        infl_idx     = idx_reg;
        infl_val     = 8'd0;
        ccnt_we      = 1'b0;
        ccnt_val     = '0;
        ram_we       = 1'b0;
        ram_waddr    = AW'(32'(idx_reg) * CAPS_PER_DEVICE + 32'(ccnt_reg[idx_reg][CW-1:0]));
        ram_wdata    = {cmd_reg.domain, cmd_reg.action, cmd_reg.algorithm};

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next  = cmd;
                    idx_next  = '0;
                    ord_next  = '0;
                    have_next = 1'b0;
                    res_next  = '{status: ST_NOTFOUND, slot: 4'd0, granted_id: 8'd0,
                                  inflight_now: 8'd0};
                    if (cmd.kind == KIND_ADD_DEV)
                    begin
                        if (count_reg >= NW'(DEVICE_SLOTS))
                            res_next.status = ST_FULL;
                        else
                        begin
                            dev_we   = 1'b1;
                            infl_we  = 1'b1;
                            infl_idx = count_reg[SW-1:0];
                            ccnt_we  = 1'b1;
                            res_next = '{status: ST_OK, slot: 4'(count_reg),
                                         granted_id: cmd.dev_num, inflight_now: 8'd0};
                            count_next = count_reg + NW'(1);
                        end
                        state_next = S_DONE;
                    end
                    else if (cmd.kind <= KIND_RELEASE && count_reg != '0 &&
                             !(cmd.kind == KIND_ACQ_PREF &&
                               cmd.fallback_types[2:0] == TYPE_END))
                        state_next = S_SLOT;
                    else
                        state_next = S_DONE;
                end
            end
            S_SLOT:
            begin
                // decide whether this slot needs a capability scan
                priority if (cmd_reg.kind == KIND_ADD_CAP || cmd_reg.kind == KIND_LOOKUP ||
                             cmd_reg.kind == KIND_RELEASE)
                begin
                    if (dev_reg[idx_reg].id == cmd_reg.dev_num)
                    begin
                        have_next  = 1'b1;
                        best_next  = idx_reg;
                        state_next = S_FIN;
                    end
                    else
                        state_next = S_NEXT;
                end
                else if (dev_reg[idx_reg].enabled && infl_reg[idx_reg] < dev_reg[idx_reg].limit &&
                         (cmd_reg.kind == KIND_ACQ_PREF ?
                          (cur_type == TYPE_ANY || dev_reg[idx_reg].dtype == cur_type) :
                          dev_reg[idx_reg].id == cmd_reg.dev_num))
                begin
                    cap_next   = '0;
                    sup_next   = 1'b0;
                    state_next = S_CAP;
                end
                else
                    state_next = S_NEXT;
            end
            S_CAP:
            begin
                // ram read issued for cap_reg; data arrives next cycle
                if (rd_pend_reg && cap_match(ram_rdata, cmd_reg.domain, cmd_reg.action,
                                             cmd_reg.algorithm))
                    sup_next = 1'b1;
                if (cap_reg < ccnt_reg[idx_reg] && !sup_next)
                begin
                    rd_pend_next = 1'b1;
                    cap_next     = cap_reg + KW'(1);
                end
                else if (!rd_pend_reg || sup_next || cap_reg >= ccnt_reg[idx_reg])
                begin
                    if (rd_pend_reg && !sup_next && cap_reg < ccnt_reg[idx_reg])
                        state_next = S_CAP;
                    else if (sup_next)
                    begin
                        if (cmd_reg.kind == KIND_ACQ_HINT)
                        begin
                            have_next  = 1'b1;
                            best_next  = idx_reg;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            if (!have_reg || beats)
                            begin
                                have_next = 1'b1;
                                best_next = idx_reg;
                            end
                            state_next = S_NEXT;
                        end
                    end
                    else
                        state_next = S_NEXT;
                end
            end
            S_NEXT:
            begin
                if (!last_slot)
                begin
                    idx_next   = idx_reg + SW'(1);
                    state_next = S_SLOT;
                end
                else if (cmd_reg.kind == KIND_ACQ_PREF && !have_reg &&
                         32'(ord_reg) + 1 < FALLBACK_SLOTS)
                begin
                    ord_next   = ord_reg + OW'(1);
                    idx_next   = '0;
                    state_next = (((3 * (32'(ord_reg) + 1) < 12) ?
                                   3'({20'd0, cmd_reg.fallback_types} >>
                                      (3 * (32'(ord_reg) + 1))) : TYPE_ANY) == TYPE_END)
                                 ? S_FIN : S_SLOT;
                end
                else
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                state_next = S_DONE;
                if (have_reg)
                begin
                    res_next = '{status: ST_OK, slot: 4'(best_reg),
                                 granted_id: dev_reg[best_reg].id,
                                 inflight_now: infl_reg[best_reg]};
                    infl_idx = best_reg;
                    unique case (cmd_reg.kind)
                        KIND_ACQ_HINT, KIND_ACQ_PREF:
                        begin
                            infl_we  = 1'b1;
                            infl_val = infl_reg[best_reg] + 8'd1;
                            res_next.inflight_now = infl_val;
                        end
                        KIND_RELEASE:
                        begin
                            infl_we  = 1'b1;
                            infl_val = (infl_reg[best_reg] != 8'd0) ?
                                       infl_reg[best_reg] - 8'd1 : 8'd0;
                            res_next.inflight_now = infl_val;
                        end
                        KIND_ADD_CAP:
                        begin
                            if (ccnt_reg[best_reg] >= KW'(CAPS_PER_DEVICE))
                                res_next.status = ST_FULL;
                            else
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = AW'(32'(best_reg) * CAPS_PER_DEVICE +
                                                32'(ccnt_reg[best_reg][CW-1:0]));
                                ccnt_we   = 1'b1;
                                infl_idx  = best_reg;
                                ccnt_val  = ccnt_reg[best_reg] + KW'(1);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_DONE:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            done_reg    <= 1'b0;
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            done_reg    <= done_next;
            rd_pend_reg <= rd_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        idx_reg  <= idx_next;
        cap_reg  <= cap_next;
        sup_reg  <= sup_next;
        ord_reg  <= ord_next;
        have_reg <= have_next;
        best_reg <= best_next;
        res_reg  <= res_next;
        if (dev_we)
            dev_reg[w_idx] <= '{id: cmd.dev_num, dtype: cmd.device_type,
                                enabled: cmd.enabled, limit: cmd.credit_max,
                                prio: cmd.priority_req, scores: cmd.scores};
        if (infl_we)
            infl_reg[infl_idx] <= infl_val;
        if (ccnt_we)
            ccnt_reg[infl_idx] <= ccnt_val;
    end

    `DDS_ASSERT(a_done_pulse, done |=> !done, "result strobe longer than one cycle")
    `DDS_ASSERT(a_count_bound, count_reg <= NW'(DEVICE_SLOTS), "device count overflow")
    `DDS_ASSERT(a_start_busy, (start && !busy) |=> busy, "command not taken")
    `DDS_ASSERT_ALWAYS(a_done_idle, !rst_n || !done || !busy, "result while busy")

endmodule

### design/dds_ram.sv
// generic simple dual-port ram (one write port, one read port) with registered read
module dds_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### design/dds_rank.sv
// candidate compare unit: does the candidate beat the current best
module dds_rank
    import dds_pkg::*;
(
    input  logic [1:0]  preference,
    input  dds_dev_t    cand,
    input  logic [7:0]  cand_infl,
    input  dds_dev_t    best,
    input  logic [7:0]  best_infl,
    output logic        beats
);

    logic [7:0] cs;
    logic [7:0] bs;
    logic       use_score;

    always_comb
    begin
        use_score = (preference == PREF_SEC) || (preference == PREF_EFF);
        cs = (preference == PREF_SEC) ? cand.scores[15:8] : cand.scores[7:0];
        bs = (preference == PREF_SEC) ? best.scores[15:8] : best.scores[7:0];
        priority if (use_score && cs != bs)
            beats = cs > bs;
        else if (cand.prio != best.prio)
            beats = cand.prio < best.prio;
        else if (cand_infl != best_infl)
            beats = cand_infl < best_infl;
        else
            beats = cand.id < best.id;
    end

endmodule
